// ===== src/dtfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtfp_pkg
// shared widths, character codes, status and sign codes, token state types
// ----------------------------------------------------------------------------
package dtfp_pkg;

   localparam int MAX_DIGITS = 18;
   localparam int SYMBOL_W   = 8;
   localparam int MAG_W      = 60;
   localparam int NUM_W      = 61;
   localparam int CNT_W      = 5;
   localparam int DIGIT_W    = 4;

   localparam logic [SYMBOL_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [SYMBOL_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [SYMBOL_W-1:0] CHAR_POINT = 8'h2e;
   localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'h2b;
   localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2d;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SYNTAX   = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MARK_NONE     = 2'd0,
      MARK_PLUS     = 2'd1,
      MARK_NEG_ZERO = 2'd2
   } mark_type;

   typedef struct packed {
      logic [MAG_W-1:0]        magnitude;
      logic signed [NUM_W-1:0] neg_magnitude;
      logic                    mag_zero;
      logic [CNT_W-1:0]        frac_count;
      logic [CNT_W-1:0]        int_count;
      logic                    point_seen;
      logic                    minus_seen;
      logic                    plus_seen;
      logic                    at_start;
      status_type              error;
   } token_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] numerator;
      logic [CNT_W-1:0]        fraction_digits;
      logic [CNT_W-1:0]        integer_digits;
      mark_type                sign_mark;
      status_type              status;
   } result_type;

   function automatic token_type token_reset();
      token_type t;
      t.magnitude     = '0;
      t.neg_magnitude = '0;
      t.mag_zero      = 1'b1;
      t.frac_count    = '0;
      t.int_count     = '0;
      t.point_seen    = 1'b0;
      t.minus_seen    = 1'b0;
      t.plus_seen     = 1'b0;
      t.at_start      = 1'b1;
      t.error         = STATUS_OK;
      return t;
   endfunction

endpackage
`default_nettype wire

// ===== src/dtfp_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtfp_step
// one character of token parsing: next token state and the result it implies
// ----------------------------------------------------------------------------
module dtfp_step (
   input  wire logic [dtfp_pkg::SYMBOL_W-1:0] symbol,
   input  wire dtfp_pkg::token_type           cur,
   output dtfp_pkg::token_type                nxt,
   output dtfp_pkg::result_type               result
);
   import dtfp_pkg::*;

   logic                 is_digit;
   logic [DIGIT_W-1:0]   digit;
   logic [CNT_W:0]       total;
   logic [MAG_W-1:0]     mag_times_ten;
   logic [NUM_W-1:0]     neg_times_ten;

   assign is_digit = (symbol >= CHAR_ZERO) && (symbol <= CHAR_NINE);
   assign digit    = symbol[DIGIT_W-1:0];
   assign total    = {1'b0, cur.int_count} + {1'b0, cur.frac_count};

   // x*10 +/- digit as x*8 + x*2 +/- digit, one add tree per accumulator
   assign mag_times_ten = {cur.magnitude[MAG_W-4:0], 3'b000}
                        + {cur.magnitude[MAG_W-2:0], 1'b0}
                        + {{(MAG_W-DIGIT_W){1'b0}}, digit};
   assign neg_times_ten = {cur.neg_magnitude[NUM_W-4:0], 3'b000}
                        + {cur.neg_magnitude[NUM_W-2:0], 1'b0}
                        - {{(NUM_W-DIGIT_W){1'b0}}, digit};

   always_comb begin
      nxt          = cur;
      nxt.at_start = 1'b0;
      if (cur.error == STATUS_OK) begin
         if (is_digit) begin
            if (total >= (CNT_W+1)'(MAX_DIGITS)) begin
               nxt.error = STATUS_OVERFLOW;
            end else begin
               nxt.magnitude     = mag_times_ten;
               nxt.neg_magnitude = neg_times_ten;
               nxt.mag_zero      = cur.mag_zero && (digit == '0);
               if (cur.point_seen) begin
                  nxt.frac_count = cur.frac_count + 1'b1;
               end else begin
                  nxt.int_count = cur.int_count + 1'b1;
               end
            end
         end else if (symbol == CHAR_POINT) begin
            if (cur.point_seen) begin
               nxt.error = STATUS_SYNTAX;
            end else begin
               nxt.point_seen = 1'b1;
            end
         end else if (cur.at_start && symbol == CHAR_PLUS) begin
            nxt.plus_seen = 1'b1;
         end else if (cur.at_start && symbol == CHAR_MINUS) begin
            nxt.minus_seen = 1'b1;
         end else begin
            nxt.error = STATUS_SYNTAX;
         end
      end
   end

   always_comb begin
      result.numerator       = '0;
      result.fraction_digits = '0;
      result.integer_digits  = '0;
      result.sign_mark       = MARK_NONE;
      result.status          = nxt.error;
      if (nxt.error == STATUS_OK) begin
         result.numerator       = nxt.minus_seen ? nxt.neg_magnitude
                                                 : $signed({1'b0, nxt.magnitude});
         result.fraction_digits = nxt.frac_count;
         result.integer_digits  = nxt.int_count;
         if (nxt.plus_seen) begin
            result.sign_mark = MARK_PLUS;
         end else if (nxt.minus_seen && nxt.mag_zero) begin
            result.sign_mark = MARK_NEG_ZERO;
         end
      end
   end

endmodule
`default_nettype wire

// ===== src/decimal_text_to_fixed_point_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_core
// parses a decimal token one character per beat into a signed scaled value
// ----------------------------------------------------------------------------
// One character is taken per clock, back to back, unless a last_symbol beat
// waits in the input register while the previous result is not yet taken.
// Each character passes the input register, then a single step that
// multiplies by ten and adds the digit to update the token state; the last
// character also loads the result register. No other loop limits the rate.
// Input keeps flowing while a result waits, up to the next last_symbol beat.
module decimal_text_to_fixed_point_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [dtfp_pkg::SYMBOL_W-1:0]       req_symbol,
   input  wire logic                                req_last_symbol,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [dtfp_pkg::NUM_W-1:0]        rsp_numerator,
   output logic [dtfp_pkg::CNT_W-1:0]               rsp_fraction_digits,
   output logic [dtfp_pkg::CNT_W-1:0]               rsp_integer_digits,
   output logic [1:0]                               rsp_sign_mark,
   output logic [1:0]                               rsp_status
);
   import dtfp_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic [SYMBOL_W-1:0] symbol_ff, symbol_in;
   logic                last_ff, last_in;
   token_type           tok_ff, tok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_ff, rsp_in;

   token_type           tok_next;
   result_type          step_result;
   logic                step_fire;
   logic                req_fire;

   dtfp_step u_step (
      .symbol (symbol_ff),
      .cur    (tok_ff),
      .nxt    (tok_next),
      .result (step_result)
   );

   assign step_fire = in_valid_ff && (!last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      symbol_in   = symbol_ff;
      last_in     = last_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      if (req_fire) begin
         symbol_in = req_symbol;
         last_in   = req_last_symbol;
      end
   end

   always_comb begin
      tok_in       = tok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (step_fire) begin
         if (last_ff) begin
            tok_in       = token_reset();
            rsp_valid_in = 1'b1;
            rsp_in       = step_result;
         end else begin
            tok_in = tok_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         tok_ff       <= token_reset();
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         tok_ff       <= tok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      symbol_ff <= symbol_in;
      last_ff   <= last_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_numerator       = rsp_ff.numerator;
   assign rsp_fraction_digits = rsp_ff.fraction_digits;
   assign rsp_integer_digits  = rsp_ff.integer_digits;
   assign rsp_sign_mark       = rsp_ff.sign_mark;
   assign rsp_status          = rsp_ff.status;

   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STATUS_OK |->
         rsp_ff.numerator == '0 && rsp_ff.sign_mark == MARK_NONE)
      else $error("errored result carries nonzero fields");

   a_digit_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STATUS_OK |->
         ({1'b0, rsp_ff.integer_digits} + {1'b0, rsp_ff.fraction_digits})
            <= (CNT_W+1)'(MAX_DIGITS))
      else $error("ok result exceeds digit limit");

   a_neg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.sign_mark == MARK_NEG_ZERO |-> rsp_ff.numerator == '0)
      else $error("negative zero mark with nonzero numerator");

   a_token_restart: assert property (@(posedge clock) disable iff (reset)
      step_fire && last_ff |=> tok_ff.at_start && tok_ff.error == STATUS_OK)
      else $error("token state not cleared after final beat");

   a_mag_pair: assert property (@(posedge clock) disable iff (reset)
      tok_ff.error == STATUS_OK |->
         tok_ff.neg_magnitude == -$signed({1'b0, tok_ff.magnitude}))
      else $error("magnitude accumulators disagree");

endmodule
`default_nettype wire
